[design/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define VPW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define VPW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/vpw_pkg.sv]
// shared types and constants for the vertex projection pipeline
// no dependencies
package vpw_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ACTION_BITS   = 2;
  localparam int IDX_BITS      = 4;
  localparam int CFG_BITS      = 16;
  localparam int CFG_IDX_BITS  = 2;

  // item kinds
  typedef logic [ACTION_BITS-1:0] action_t;
  localparam action_t ACT_LOAD_MV   = 2'd0;
  localparam action_t ACT_LOAD_PROJ = 2'd1;
  localparam action_t ACT_PROJECT   = 2'd2;

  // configuration register indexes
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ORIGIN_X = 2'd0;
  localparam cfg_idx_t CFG_ORIGIN_Y = 2'd1;
  localparam cfg_idx_t CFG_WIDTH    = 2'd2;
  localparam cfg_idx_t CFG_HEIGHT   = 2'd3;

  typedef logic [CFG_BITS-1:0] cfg_word_t;

  localparam cfg_word_t VIEW_WIDTH_RST  = 16'd640;
  localparam cfg_word_t VIEW_HEIGHT_RST = 16'd480;

  // viewport settings handed to the mapping stage
  typedef struct packed {
    cfg_word_t origin_x;
    cfg_word_t origin_y;
    cfg_word_t width;
    cfg_word_t height;
  } view_cfg_t;

endpackage

[design/vpw_xform.sv]
// 4x4 matrix times 4-vector, two stages: products, then rounded sum with saturation
// holds its own matrix, loaded by items of kind LOAD_ACT; uses vpw_pkg
module vpw_xform #(
  parameter int WORD_BITS = vpw_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vpw_pkg::FRAC_BITS_DEF,
  parameter vpw_pkg::action_t LOAD_ACT = vpw_pkg::ACT_LOAD_MV
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  vpw_pkg::action_t              in_action,
  input  logic [vpw_pkg::IDX_BITS-1:0]  in_idx,
  input  logic [WORD_BITS-1:0]          in_value,
  input  logic [3:0][WORD_BITS-1:0]     in_vec,
  output logic                          out_valid,
  input  logic                          out_ready,
  output vpw_pkg::action_t              out_action,
  output logic [vpw_pkg::IDX_BITS-1:0]  out_idx,
  output logic [WORD_BITS-1:0]          out_value,
  output logic [3:0][WORD_BITS-1:0]     out_vec
);
  import vpw_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 3;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SMAX = SW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  logic [15:0][W-1:0]  mat_r;
  logic                v1_r, v2_r, rdy1, rdy2;
  action_t             act1_r, act2_r;
  logic [IDX_BITS-1:0] idx1_r, idx2_r;
  logic [W-1:0]        val1_r, val2_r;
  logic [15:0][PW-1:0] prod1_r, prod_nxt;
  logic [3:0][W-1:0]   vec2_r, vec_nxt;

  // stage handshake
  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // matrix storage, identity after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end else if (in_valid && rdy1 && in_action == LOAD_ACT) begin
      mat_r[in_idx] <= in_value;
    end
  end

  // full-width products, entry index is column*4 + row
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        prod_nxt[c*4+r] = $signed({{W{mat_r[c*4+r][W-1]}}, mat_r[c*4+r]})
                        * $signed({{W{in_vec[c][W-1]}}, in_vec[c]});
      end
    end
  end

  // round each product, sum a row, saturate
  always_comb begin
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] term;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        term = ($signed({{3{prod1_r[c*4+r][PW-1]}}, prod1_r[c*4+r]}) + HALF) >>> FRAC_BITS;
        acc  = acc + term;
      end
      if (acc > SMAX) begin
        vec_nxt[r] = SMAX[W-1:0];
      end else if (acc < SMIN) begin
        vec_nxt[r] = SMIN[W-1:0];
      end else begin
        vec_nxt[r] = acc[W-1:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      act1_r  <= in_action;
      idx1_r  <= in_idx;
      val1_r  <= in_value;
      prod1_r <= prod_nxt;
    end
    if (rdy2 && v1_r) begin
      act2_r <= act1_r;
      idx2_r <= idx1_r;
      val2_r <= val1_r;
      vec2_r <= vec_nxt;
    end
  end

  assign out_valid  = v2_r;
  assign out_action = act2_r;
  assign out_idx    = idx2_r;
  assign out_value  = val2_r;
  assign out_vec    = vec2_r;

endmodule

[design/vpw_divider.sv]
// divides three clip coordinates by clip w, one quotient bit per stage
// prep stage, WORD_BITS restoring steps, saturating final stage; uses vpw_pkg
module vpw_divider #(
  parameter int WORD_BITS = vpw_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vpw_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [3:0][WORD_BITS-1:0] in_clip,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0][WORD_BITS-1:0] out_ndc,
  output logic                      out_ok
);
  import vpw_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int RW = ((W + FRAC_BITS > 2 * W) ? W + FRAC_BITS : 2 * W) + 1;
  localparam int NS = W + 1;
  localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

  logic                 v_r   [NS];
  logic                 rdy   [NS];
  logic [2:0][RW-1:0]   rem_r [NS];
  logic [2:0][W-1:0]    q_r   [NS];
  logic [W-1:0]         d_r   [NS];
  logic [2:0]           neg_r [NS];
  logic [2:0]           ovf_r [NS];
  logic                 ok_r  [NS];

  logic                 vf_r, okf_r, rdyf;
  logic [2:0][W-1:0]    ndc_r, ndc_nxt;

  logic                 wneg;
  logic [W-1:0]         dmag;
  logic [2:0]           cneg, ovf_nxt;
  logic [2:0][W-1:0]    cmag;
  logic [2:0][RW-1:0]   dvd;

  // ready chain
  genvar k;
  generate
    for (k = 0; k < NS - 1; k++) begin : g_rdy
      assign rdy[k] = !v_r[k] || rdy[k+1];
    end
  endgenerate
  assign rdy[NS-1] = !v_r[NS-1] || rdyf;
  assign rdyf      = !vf_r || out_ready;
  assign in_ready  = rdy[0];

  // magnitudes, signs and the range check
  always_comb begin
    wneg = in_clip[3][W-1];
    dmag = wneg ? (~in_clip[3] + W'(1)) : in_clip[3];
    for (int l = 0; l < 3; l++) begin
      cneg[l]    = in_clip[l][W-1];
      cmag[l]    = cneg[l] ? (~in_clip[l] + W'(1)) : in_clip[l];
      dvd[l]     = RW'(cmag[l]) << FRAC_BITS;
      ovf_nxt[l] = dvd[l] >= (RW'(dmag) << W);
    end
  end

  // prep stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      rem_r[0] <= dvd;
      q_r[0]   <= '0;
      d_r[0]   <= dmag;
      neg_r[0] <= cneg ^ {3{wneg}};
      ovf_r[0] <= ovf_nxt;
      ok_r[0]  <= (in_clip[3] != '0);
    end
  end

  // restoring steps, quotient bit W-k at step k
  generate
    for (k = 1; k < NS; k++) begin : g_step
      localparam int B = W - k;
      logic [RW-1:0]      sub;
      logic [2:0][RW-1:0] rem_n;
      logic [2:0]         qb;

      assign sub = RW'(d_r[k-1]) << B;

      always_comb begin
        for (int l = 0; l < 3; l++) begin
          qb[l]    = rem_r[k-1][l] >= sub;
          rem_n[l] = qb[l] ? (rem_r[k-1][l] - sub) : rem_r[k-1][l];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k] && v_r[k-1]) begin
          rem_r[k] <= rem_n;
          for (int l = 0; l < 3; l++) begin
            q_r[k][l] <= q_r[k-1][l] | ({{(W-1){1'b0}}, qb[l]} << B);
          end
          d_r[k]   <= d_r[k-1];
          neg_r[k] <= neg_r[k-1];
          ovf_r[k] <= ovf_r[k-1];
          ok_r[k]  <= ok_r[k-1];
        end
      end
    end
  endgenerate

  // apply sign and saturate
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (ovf_r[NS-1][l]) begin
        ndc_nxt[l] = neg_r[NS-1][l] ? MINN : MAXP;
      end else if (neg_r[NS-1][l]) begin
        ndc_nxt[l] = (q_r[NS-1][l] > MINN) ? MINN : (~q_r[NS-1][l] + W'(1));
      end else begin
        ndc_nxt[l] = (q_r[NS-1][l] > MAXP) ? MAXP : q_r[NS-1][l];
      end
    end
  end

  // final stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (rdyf) begin
      vf_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdyf && v_r[NS-1]) begin
      ndc_r <= ndc_nxt;
      okf_r <= ok_r[NS-1];
    end
  end

  assign out_valid = vf_r;
  assign out_ndc   = ndc_r;
  assign out_ok    = okf_r;

endmodule

[design/vpw_viewport.sv]
// maps normalized coordinates to window coordinates and depth
// two stages: scale by viewport size, then offset, halve and saturate; uses vpw_pkg
module vpw_viewport #(
  parameter int WORD_BITS = vpw_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vpw_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0][WORD_BITS-1:0] in_ndc,
  input  logic                      in_ok,
  input  vpw_pkg::view_cfg_t        cfg,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0][WORD_BITS-1:0] out_win,
  output logic                      out_ok
);
  import vpw_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int HW = W + 1;
  localparam int MW = HW + CFG_BITS + 1;
  localparam int PW = ((MW > FRAC_BITS + CFG_BITS + 1) ? MW : FRAC_BITS + CFG_BITS + 1) + 1;
  localparam logic signed [HW-1:0] ONE_H = HW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] SMAX  = PW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [PW-1:0] SMIN  = ~SMAX;

  logic              va_r, vb_r, rdya, rdyb;
  logic              oka_r, okb_r;
  logic [MW-1:0]     mx_r, my_r, mx_nxt, my_nxt;
  logic [HW-1:0]     hz_r;
  logic signed [HW-1:0] hx, hy, hz;
  logic [2:0][W-1:0] win_r, win_nxt;

  assign rdyb     = !vb_r || out_ready;
  assign rdya     = !va_r || rdyb;
  assign in_ready = rdya;

  // one plus ndc, scaled by width and height
  always_comb begin
    hx = $signed({in_ndc[0][W-1], in_ndc[0]}) + ONE_H;
    hy = $signed({in_ndc[1][W-1], in_ndc[1]}) + ONE_H;
    hz = $signed({in_ndc[2][W-1], in_ndc[2]}) + ONE_H;
    mx_nxt = $signed({{(MW-HW){hx[HW-1]}}, hx})
           * $signed({{(MW-CFG_BITS){1'b0}}, cfg.width});
    my_nxt = $signed({{(MW-HW){hy[HW-1]}}, hy})
           * $signed({{(MW-CFG_BITS){1'b0}}, cfg.height});
  end

  // offset, floor halving, saturation; failed items read as zero
  always_comb begin
    logic signed [PW-1:0] wx;
    logic signed [PW-1:0] wy;
    logic signed [HW-1:0] wz;
    wx = $signed(PW'(cfg.origin_x) << FRAC_BITS)
       + ($signed({{(PW-MW){mx_r[MW-1]}}, mx_r}) >>> 1);
    wy = $signed(PW'(cfg.origin_y) << FRAC_BITS)
       + ($signed({{(PW-MW){my_r[MW-1]}}, my_r}) >>> 1);
    wz = $signed(hz_r) >>> 1;
    win_nxt[0] = (wx > SMAX) ? SMAX[W-1:0] : (wx < SMIN) ? SMIN[W-1:0] : wx[W-1:0];
    win_nxt[1] = (wy > SMAX) ? SMAX[W-1:0] : (wy < SMIN) ? SMIN[W-1:0] : wy[W-1:0];
    win_nxt[2] = wz[W-1:0];
    if (!oka_r) begin
      win_nxt = '0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdya) va_r <= in_valid;
      if (rdyb) vb_r <= va_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdya && in_valid) begin
      mx_r  <= mx_nxt;
      my_r  <= my_nxt;
      hz_r  <= hz;
      oka_r <= in_ok;
    end
    if (rdyb && va_r) begin
      win_r <= win_nxt;
      okb_r <= oka_r;
    end
  end

  assign out_valid = vb_r;
  assign out_win   = win_r;
  assign out_ok    = okb_r;

endmodule

[design/vertex_projection_to_window.sv]
// channel | dir | contents
// in_     | in  | tuser: action; tdata: entry_index, entry_value, obj_x, obj_y, obj_z
// out_    | out | tuser: valid_res; tdata: win_x, win_y, win_depth
// cfg_    | in  | write enable, register index, 16-bit data
// one word per cycle in and out while no stage is stalled; the divider
// resolves one quotient bit per stage
// synchronous active-low reset restores identity matrices and default viewport
// every stage has a valid bit; a stall holds words in place and fills bubbles
//
// top level of the vertex projection pipeline
// uses vpw_pkg, vpw_xform, vpw_divider, vpw_viewport
module vertex_projection_to_window #(
  parameter int WORD_BITS = vpw_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vpw_pkg::FRAC_BITS_DEF,
  parameter int IN_DW     = ((4 * WORD_BITS + vpw_pkg::IDX_BITS + 7) / 8) * 8,
  parameter int OUT_DW    = ((3 * WORD_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // entry_index, entry_value, obj_x, obj_y, obj_z, zero pad
  input  logic [IN_DW-1:0]               in_tdata,
  // action
  input  logic [vpw_pkg::ACTION_BITS-1:0] in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // win_x, win_y, win_depth, zero pad
  output logic [OUT_DW-1:0]              out_tdata,
  // valid_res
  output logic [0:0]                     out_tuser,
  input  logic                           cfg_we,
  input  vpw_pkg::cfg_idx_t              cfg_idx,
  input  vpw_pkg::cfg_word_t             cfg_wdata
);
  import vpw_pkg::*;

  localparam int W = WORD_BITS;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  view_cfg_t view_r;

  logic               mv_ready, mv_valid, pj_ready, pj_valid, pj_out_ready;
  action_t            mv_action, pj_action;
  logic [IDX_BITS-1:0] mv_idx, pj_idx;
  logic [W-1:0]       mv_value, pj_value;
  logic [3:0][W-1:0]  obj_vec, eye_vec, clip_vec;
  logic               dv_in_valid, dv_in_ready, dv_valid, dv_ready, dv_ok;
  logic [2:0][W-1:0]  ndc;
  logic               vp_ok;
  logic [2:0][W-1:0]  win;

  // viewport registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r.origin_x <= '0;
      view_r.origin_y <= '0;
      view_r.width    <= VIEW_WIDTH_RST;
      view_r.height   <= VIEW_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ORIGIN_X: view_r.origin_x <= cfg_wdata;
        CFG_ORIGIN_Y: view_r.origin_y <= cfg_wdata;
        CFG_WIDTH:    view_r.width    <= cfg_wdata;
        CFG_HEIGHT:   view_r.height   <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // object point with w of one
  assign obj_vec[0] = in_tdata[2*W+3:W+4];
  assign obj_vec[1] = in_tdata[3*W+3:2*W+4];
  assign obj_vec[2] = in_tdata[4*W+3:3*W+4];
  assign obj_vec[3] = ONE;

  vpw_xform #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .LOAD_ACT  (ACT_LOAD_MV)
  ) u_modelview (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_tuser),
    .in_idx     (in_tdata[IDX_BITS-1:0]),
    .in_value   (in_tdata[W+3:4]),
    .in_vec     (obj_vec),
    .out_valid  (mv_valid),
    .out_ready  (mv_ready),
    .out_action (mv_action),
    .out_idx    (mv_idx),
    .out_value  (mv_value),
    .out_vec    (eye_vec)
  );

  vpw_xform #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .LOAD_ACT  (ACT_LOAD_PROJ)
  ) u_projection (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (mv_valid),
    .in_ready   (mv_ready),
    .in_action  (mv_action),
    .in_idx     (mv_idx),
    .in_value   (mv_value),
    .in_vec     (eye_vec),
    .out_valid  (pj_valid),
    .out_ready  (pj_out_ready),
    .out_action (pj_action),
    .out_idx    (pj_idx),
    .out_value  (pj_value),
    .out_vec    (clip_vec)
  );

  // only project words go on; loads and unused kinds end here
  assign pj_ready     = (pj_action == ACT_PROJECT) ? dv_in_ready : 1'b1;
  assign pj_out_ready = pj_ready || (pj_idx != pj_idx) || (pj_value != pj_value);
  assign dv_in_valid  = pj_valid && (pj_action == ACT_PROJECT);

  vpw_divider #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_in_valid),
    .in_ready  (dv_in_ready),
    .in_clip   (clip_vec),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_ndc   (ndc),
    .out_ok    (dv_ok)
  );

  vpw_viewport #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_viewport (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_ndc    (ndc),
    .in_ok     (dv_ok),
    .cfg       (view_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_win   (win),
    .out_ok    (vp_ok)
  );

  assign out_tdata    = OUT_DW'({win[2], win[1], win[0]});
  assign out_tuser[0] = vp_ok;

endmodule

[design/vpw_checker.sv]
// port-level checks for the vertex projection pipeline, bound to the top level
// uses vpw_pkg and assert_macros.svh
`include "assert_macros.svh"
module vpw_checker #(
  parameter int WORD_BITS = vpw_pkg::WORD_BITS_DEF,
  parameter int OUT_DW    = ((3 * WORD_BITS + 7) / 8) * 8
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [OUT_DW-1:0]               out_tdata,
  input logic [0:0]                      out_tuser
);
  import vpw_pkg::*;

  // reset empties the pipeline
  `VPW_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

  // a stalled result holds
  `VPW_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled word changed")

  // an empty output stage means every stage can take a word
  `VPW_ASSERT(a_in_ready, clk, rst_n, !out_tvalid |-> in_tready, "input stalled with empty output")

  // a zero-w result carries zero coordinates
  `VPW_ASSERT(a_fail_zero, clk, rst_n, out_tvalid && !out_tuser[0] |-> out_tdata == '0, "failed point not zeroed")

endmodule

bind vertex_projection_to_window vpw_checker #(
  .WORD_BITS (WORD_BITS),
  .OUT_DW    (OUT_DW)
) u_vpw_checker (.*);
